### rtl/core/lpng_pkg.sv
// ----------------------------------------------------------------------------
// lpng_pkg - LIKE pattern n-gram extractor package
// Shared types, character codes and the UTF-8 lead byte decode.
// ----------------------------------------------------------------------------
package lpng_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_W  = 4;

    localparam logic [CFG_W-1:0]  GRAM_RESET    = 4'd3;

    localparam logic [BYTE_W-1:0] CH_PERCENT    = 8'h25;
    localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [BYTE_W-1:0] ASCII_LIMIT   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD_INVALID  = 8'hF8;

    // One code point as held in a window cell, first byte in the low lane
    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  size;
    } point_t;

    // Front end to window control
    typedef struct packed {
        logic   push;   // completed code point enters the window
        logic   wipe;   // window empties after this word
        point_t point;
    } front_ctrl_t;

    // Code point length from its first byte
    function automatic logic [2:0] lead_length(input logic [BYTE_W-1:0] b);
        logic [2:0] len;
        if (b < ASCII_LIMIT || b >= LEAD_INVALID)
            len = 3'd1;
        else if (b[6] == 1'b0)
            len = 3'd1;
        else if (b[5] == 1'b0)
            len = 3'd2;
        else if (b[4] == 1'b0)
            len = 3'd3;
        else
            len = 3'd4;
        return len;
    endfunction

endpackage

### rtl/core/lpng_if.sv
// ----------------------------------------------------------------------------
// lpng_if - channel interfaces
// Valid/ready channels for pattern bytes in and n-gram bytes out.
// ----------------------------------------------------------------------------
interface lpng_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pattern_byte;
    logic       end_of_pattern;

    modport source (output valid, output pattern_byte, output end_of_pattern, input ready);
    modport sink   (input valid, input pattern_byte, input end_of_pattern, output ready);
endinterface

interface lpng_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] gram_byte;
    logic       gram_last;

    modport source (output valid, output gram_byte, output gram_last, input ready);
    modport sink   (input valid, input gram_byte, input gram_last, output ready);
endinterface

### rtl/core/lpng_front.sv
// ----------------------------------------------------------------------------
// lpng_front - escape handling and UTF-8 code point assembly
// Turns accepted pattern bytes into window pushes and window wipes.
// ----------------------------------------------------------------------------
module lpng_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           pattern_byte,
    input  logic                 end_of_pattern,
    output lpng_pkg::front_ctrl_t ctrl
);

    logic        esc_reg,    esc_next;
    logic [31:0] pbytes_reg, pbytes_next;
    logic [2:0]  pexp_reg,   pexp_next;
    logic [2:0]  prcv_reg,   prcv_next;

    logic [31:0] merged;
    logic [2:0]  rcv_inc;
    logic [2:0]  lead;
    logic        is_lit;
    logic        is_wild;

    always_comb
    begin
        merged  = pbytes_reg | (32'(pattern_byte) << {prcv_reg[1:0], 3'b000});
        rcv_inc = prcv_reg + 3'd1;
        lead    = lpng_pkg::lead_length(pattern_byte);
        is_lit  = (pattern_byte == lpng_pkg::CH_PERCENT)
               || (pattern_byte == lpng_pkg::CH_UNDERSCORE)
               || (pattern_byte == lpng_pkg::CH_BACKSLASH);
        is_wild = (pattern_byte == lpng_pkg::CH_PERCENT)
               || (pattern_byte == lpng_pkg::CH_UNDERSCORE)
               || (pattern_byte == lpng_pkg::CH_SPACE);

        esc_next    = esc_reg;
        pbytes_next = pbytes_reg;
        pexp_next   = pexp_reg;
        prcv_next   = prcv_reg;
        ctrl        = '0;

        if (accept)
        begin
            if (pexp_reg != 3'd0)
            begin
                // continuation bytes taken raw
                if (rcv_inc >= pexp_reg)
                begin
                    ctrl.push        = 1'b1;
                    ctrl.point.bytes = merged;
                    ctrl.point.size  = pexp_reg;
                    pbytes_next      = '0;
                    pexp_next        = 3'd0;
                    prcv_next        = 3'd0;
                end
                else
                begin
                    pbytes_next = merged;
                    prcv_next   = rcv_inc;
                end
            end
            else if (esc_reg && is_lit)
            begin
                esc_next         = 1'b0;
                ctrl.push        = 1'b1;
                ctrl.point.bytes = 32'(pattern_byte);
                ctrl.point.size  = 3'd1;
            end
            else if (!esc_reg && is_wild)
            begin
                ctrl.wipe = 1'b1;
            end
            else if (!esc_reg && pattern_byte == lpng_pkg::CH_BACKSLASH)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                esc_next = 1'b0;
                if (lead == 3'd1)
                begin
                    ctrl.push        = 1'b1;
                    ctrl.point.bytes = 32'(pattern_byte);
                    ctrl.point.size  = 3'd1;
                end
                else
                begin
                    pbytes_next = 32'(pattern_byte);
                    pexp_next   = lead;
                    prcv_next   = 3'd1;
                end
            end

            if (end_of_pattern)
            begin
                ctrl.wipe   = 1'b1;
                esc_next    = 1'b0;
                pbytes_next = '0;
                pexp_next   = 3'd0;
                prcv_next   = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg    <= 1'b0;
            pbytes_reg <= '0;
            pexp_reg   <= 3'd0;
            prcv_reg   <= 3'd0;
        end
        else
        begin
            esc_reg    <= esc_next;
            pbytes_reg <= pbytes_next;
            pexp_reg   <= pexp_next;
            prcv_reg   <= prcv_next;
        end
    end

endmodule

### rtl/core/lpng_cell.sv
// ----------------------------------------------------------------------------
// lpng_cell - one window cell
// Holds one code point; takes its neighbour's point on each push.
// ----------------------------------------------------------------------------
module lpng_cell (
    input  logic             clk,
    input  logic             shift,
    input  lpng_pkg::point_t din,
    output lpng_pkg::point_t dout
);

    lpng_pkg::point_t pt_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
            pt_reg <= din;
    end

    assign dout = pt_reg;

endmodule

### rtl/core/lpng_emit.sv
// ----------------------------------------------------------------------------
// lpng_emit - n-gram byte emitter
// Walks the window cells oldest first, one byte per cycle while gram is
// ready, into an output register.
// ----------------------------------------------------------------------------
module lpng_emit #(
    parameter int MAX_GRAM = 8,
    localparam int IDX_W   = (MAX_GRAM > 1) ? $clog2(MAX_GRAM) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [IDX_W-1:0]     k_start,
    input  lpng_pkg::point_t     window [MAX_GRAM],
    output logic                 busy,
    lpng_out_if.source           gram
);

    logic             busy_reg,  busy_next;
    logic [IDX_W-1:0] k_reg,     k_next;
    logic [1:0]       j_reg,     j_next;
    logic             ovld_reg,  ovld_next;
    logic [7:0]       obyte_reg, obyte_next;
    logic             olast_reg, olast_next;

    lpng_pkg::point_t cur;
    logic             ld;
    logic             pt_end;

    always_comb
    begin
        cur    = window[k_reg];
        ld     = busy_reg && (!ovld_reg || gram.ready);
        pt_end = ({1'b0, j_reg} == (cur.size - 3'd1));

        busy_next  = busy_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        obyte_next = obyte_reg;
        olast_next = olast_reg;
        ovld_next  = ovld_reg && !gram.ready;

        if (start)
        begin
            busy_next = 1'b1;
            k_next    = k_start;
            j_next    = 2'd0;
        end
        else if (ld)
        begin
            ovld_next  = 1'b1;
            obyte_next = cur.bytes[{j_reg, 3'b000} +: 8];
            olast_next = pt_end && (k_reg == '0);
            if (pt_end)
            begin
                j_next = 2'd0;
                if (k_reg == '0)
                    busy_next = 1'b0;
                else
                    k_next = k_reg - 1'b1;
            end
            else
            begin
                j_next = j_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ovld_reg <= 1'b0;
            k_reg    <= '0;
            j_reg    <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            ovld_reg <= ovld_next;
            k_reg    <= k_next;
            j_reg    <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    assign busy           = busy_reg;
    assign gram.valid     = ovld_reg;
    assign gram.gram_byte = obyte_reg;
    assign gram.gram_last = olast_reg;

endmodule

### rtl/core/like_pattern_ngram_extractor_top.sv
// ----------------------------------------------------------------------------
// like_pattern_ngram_extractor_top - LIKE pattern UTF-8 n-gram extractor
// Slides a window of code points over pattern bytes and emits n-grams.
// ----------------------------------------------------------------------------
// Usage:
//   pattern : valid/ready channel, one pattern byte per word plus an
//             end-of-pattern flag. A word is taken when valid and ready meet.
//   gram    : valid/ready channel, one n-gram byte per word, oldest code
//             point first, gram_last set on the final byte of each n-gram.
//   cfg_we / cfg_data : writes gram_length (0 acts as 1, above MAX_GRAM acts
//             as MAX_GRAM). Write only while idle.
// Timing: a word that completes a full window starts the emitter at the
//   accepting edge; the emitter then loads the first n-gram byte into the
//   output register, then one byte per cycle while gram is ready; this walk
//   over the window sets the rate. pattern.ready is low while the emitter
//   walks the cells, so such a word blocks pattern; other words do not.
// Reset: gram_length returns to 3, escape, partial code point and window
//   fill clear at once; the cells need no clearing since the fill count
//   guards them.
// Stall: when gram.ready is low the output register holds its byte and the
//   emitter waits; pattern stays blocked until the last byte is loaded.
// ----------------------------------------------------------------------------
module like_pattern_ngram_extractor_top #(
    parameter int MAX_GRAM = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    lpng_in_if.sink                    pattern,
    lpng_out_if.source                 gram,
    input  logic                       cfg_we,
    input  logic [lpng_pkg::CFG_W-1:0] cfg_data
);

    localparam int IDX_W  = (MAX_GRAM > 1) ? $clog2(MAX_GRAM) : 1;
    localparam int FILL_W = $clog2(MAX_GRAM + 1);

    // configuration
    logic [lpng_pkg::CFG_W-1:0] gram_length_reg;

    // window occupancy, saturates at MAX_GRAM
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] fill_pushed;
    logic [FILL_W-1:0] eff;

    logic                  accept;
    logic                  busy;
    logic                  start;
    logic [IDX_W-1:0]      k_start;
    lpng_pkg::front_ctrl_t ctrl;
    lpng_pkg::point_t      window [MAX_GRAM];

    assign accept        = pattern.valid && pattern.ready;
    assign pattern.ready = !busy;

    lpng_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .pattern_byte   (pattern.pattern_byte),
        .end_of_pattern (pattern.end_of_pattern),
        .ctrl           (ctrl)
    );

    // Chain of cells: newest point enters cell 0, the rest move one along
    for (genvar i = 0; i < MAX_GRAM; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            lpng_cell u_cell (
                .clk   (clk),
                .shift (ctrl.push),
                .din   (ctrl.point),
                .dout  (window[i])
            );
        end
        else
        begin : g_body
            lpng_cell u_cell (
                .clk   (clk),
                .shift (ctrl.push),
                .din   (window[i-1]),
                .dout  (window[i])
            );
        end
    end

    // Effective gram length and the emit decision
    always_comb
    begin
        if (gram_length_reg == '0)
            eff = FILL_W'(1);
        else if (32'(gram_length_reg) > 32'(MAX_GRAM))
            eff = FILL_W'(MAX_GRAM);
        else
            eff = FILL_W'(gram_length_reg);

        if (fill_reg == FILL_W'(MAX_GRAM))
            fill_pushed = fill_reg;
        else
            fill_pushed = fill_reg + FILL_W'(1);

        // oldest point of the n-gram sits in cell eff-1
        start   = ctrl.push && (fill_pushed >= eff);
        k_start = IDX_W'(eff - FILL_W'(1));

        if (ctrl.wipe)
            fill_next = '0;
        else if (ctrl.push)
            fill_next = fill_pushed;
        else
            fill_next = fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gram_length_reg <= lpng_pkg::GRAM_RESET;
            fill_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
                gram_length_reg <= cfg_data;
            fill_reg <= fill_next;
        end
    end

    lpng_emit #(
        .MAX_GRAM (MAX_GRAM)
    ) u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .k_start (k_start),
        .window  (window),
        .busy    (busy),
        .gram    (gram)
    );

`ifndef SYNTHESIS
    // no pattern word taken while the emitter is busy
    a_block_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !pattern.ready)
        else $error("pattern accepted during emission");

    // an emit decision always starts the emitter
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy)
        else $error("emission did not start");

    // fill count stays within the cell chain
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= 32'(MAX_GRAM))
        else $error("window fill out of range");

    // emit decision only on a push with an accepted word
    a_start_push: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (accept && ctrl.push))
        else $error("emission without a push");
`endif

endmodule
